FILE: design/aqli_pkg.sv
package aqli_pkg;

  localparam int PM_W    = 16;
  localparam int LEVEL_W = 3;
  localparam int SENS_W  = 3;
  localparam int HOLD_W  = 16;
  localparam int THR_W   = 6;
  localparam int NUM_THR = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [SENS_W-1:0] SENS_MAX_ROW = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_SENSITIVITY       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_DROP_DISABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_SECONDS      = 2'd2;

  localparam logic [HOLD_W-1:0] HOLD_SECONDS_RESET = 16'd300;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_TICK   = 1'b1
  } aqli_cmd_t;

  typedef struct packed {
    logic              cmd;
    logic [PM_W-1:0]   pm_value;
    logic              freeze;
    logic              sleeping;
  } aqli_in_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               display_off;
  } aqli_out_t;

  typedef struct packed {
    logic [SENS_W-1:0] sensitivity;
    logic              slow_drop_disable;
    logic [HOLD_W-1:0] hold_seconds;
  } aqli_cfg_t;

  typedef logic [NUM_THR-1:0][THR_W-1:0] thr_row_t;

  // Element 0 is the lowest threshold of the row.
  function automatic thr_row_t thr_row(input logic [SENS_W-1:0] row);
    thr_row_t r;
    case (row)
      3'd0:    r = {6'd10, 6'd5,  6'd3,  6'd2};
      3'd1:    r = {6'd30, 6'd10, 6'd3,  6'd2};
      3'd2:    r = {6'd35, 6'd15, 6'd4,  6'd2};
      3'd3:    r = {6'd35, 6'd20, 6'd8,  6'd3};
      3'd4:    r = {6'd40, 6'd25, 6'd8,  6'd4};
      default: r = {6'd50, 6'd35, 6'd12, 6'd6};
    endcase
    return r;
  endfunction

endpackage

FILE: design/aqli_grade.sv
module aqli_grade import aqli_pkg::*; (
  input  logic [SENS_W-1:0]  sensitivity,
  input  logic [PM_W-1:0]    pm_value,
  output logic [LEVEL_W-1:0] target
);

  logic [SENS_W-1:0] row;
  thr_row_t          thr;
  logic [NUM_THR-1:0] above;

  assign row = (sensitivity > SENS_MAX_ROW) ? SENS_MAX_ROW : sensitivity;
  assign thr = thr_row(row);

  always_comb begin
    for (int i = 0; i < NUM_THR; i++) begin
      above[i] = pm_value >= {{(PM_W-THR_W){1'b0}}, thr[i]};
    end
  end

  // Thresholds rise along the row, so the level is the count of thresholds met.
  always_comb begin
    if (!above[0]) begin
      target = 3'd0;
    end else if (!above[1]) begin
      target = 3'd1;
    end else if (!above[2]) begin
      target = 3'd2;
    end else if (!above[3]) begin
      target = 3'd3;
    end else begin
      target = 3'd4;
    end
  end

endmodule

FILE: design/aqli_state.sv
module aqli_state import aqli_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  aqli_in_t           item,
  input  aqli_cfg_t          cfg,
  input  logic [LEVEL_W-1:0] target,
  output logic [LEVEL_W-1:0] level_next
);

  logic [LEVEL_W-1:0] shown_level;
  logic               drop_pending;
  logic [HOLD_W-1:0]  hold_countdown;
  logic               drop_pending_next;
  logic [HOLD_W-1:0]  hold_countdown_next;
  logic [HOLD_W-1:0]  cd_base;

  always_comb begin
    level_next          = shown_level;
    drop_pending_next   = drop_pending;
    hold_countdown_next = hold_countdown;
    cd_base = cfg.slow_drop_disable ? '0 : hold_countdown;
    if (item.cmd == CMD_TICK) begin
      if (drop_pending && (hold_countdown != '0)) begin
        hold_countdown_next = hold_countdown - 1'b1;
      end
    end else if (!item.freeze) begin
      hold_countdown_next = cd_base;
      if (target < shown_level) begin
        if (!drop_pending) begin
          drop_pending_next = 1'b1;
        end else if (cd_base == '0) begin
          level_next          = shown_level - 1'b1;
          hold_countdown_next = cfg.hold_seconds;
        end
      end else begin
        drop_pending_next   = 1'b0;
        hold_countdown_next = cfg.hold_seconds;
        level_next          = target;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shown_level    <= '0;
      drop_pending   <= 1'b0;
      hold_countdown <= '0;
    end else if (advance) begin
      shown_level    <= level_next;
      drop_pending   <= drop_pending_next;
      hold_countdown <= hold_countdown_next;
    end
  end

endmodule

FILE: design/air_quality_level_indicator.sv
// Air quality level indicator. Each accepted word is either a concentration
// sample or a one-second tick, and each gives exactly one result word with the
// shown level (0 blue to 4 purple) and the display blanking flag. A word is
// held in an input register, graded and applied to the level state, and lands
// in the result register, so one word is taken every cycle while the output
// is not stalled. Registers are written through cfg_we, cfg_index and
// cfg_data: 0 sensitivity, 1 slow_drop_disable, 2 hold_seconds (reset 300).
// Write them only while no word is in flight.
module air_quality_level_indicator import aqli_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  aqli_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output aqli_out_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  aqli_cfg_t          cfg;
  logic               s1_valid;
  aqli_in_t           s1_data;
  logic               advance;
  logic [LEVEL_W-1:0] target;
  logic [LEVEL_W-1:0] level_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sensitivity       <= '0;
      cfg.slow_drop_disable <= 1'b0;
      cfg.hold_seconds      <= HOLD_SECONDS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SENSITIVITY:       cfg.sensitivity       <= cfg_data[SENS_W-1:0];
        CFG_SLOW_DROP_DISABLE: cfg.slow_drop_disable <= cfg_data[0];
        CFG_HOLD_SECONDS:      cfg.hold_seconds      <= cfg_data[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data <= in_data;
    end
  end

  aqli_grade u_grade (
    .sensitivity (cfg.sensitivity),
    .pm_value    (s1_data.pm_value),
    .target      (target)
  );

  aqli_state u_state (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .item       (s1_data),
    .cfg        (cfg),
    .target     (target),
    .level_next (level_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.level       <= level_next;
      out_data.display_off <= s1_data.sleeping;
    end
  end

endmodule

FILE: dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import aqli_pkg::*;

  typedef struct {
    bit                    is_reg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    aqli_in_t              word;
    bit                    typed;
    aqli_out_t             want;
  } plan_row_t;

  localparam int PHASES          = 13;
  localparam int WORDS_PER_PHASE = 100;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  aqli_in_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  aqli_out_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [SENS_W-1:0]  sens_reg;
  logic               quick_drop_reg;
  logic [HOLD_W-1:0]  hold_reg;
  logic [LEVEL_W-1:0] shown;
  logic               drop_armed;
  logic [HOLD_W-1:0]  hold_left;

  aqli_out_t levels_due [$];
  aqli_out_t due_word;
  plan_row_t plan [$];
  int        fail_count = 0;
  int        stall_left = 0;
  bit        tx_calm = 1'b0;
  bit        rx_calm = 1'b0;

  air_quality_level_indicator i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic flag_mismatch(input string what, input int got, input int want);
    if (fail_count < 40) begin
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    end
    fail_count++;
  endtask

  function automatic logic [3:0][HOLD_W-1:0] limit_row(input logic [SENS_W-1:0] s);
    logic [3:0][HOLD_W-1:0] r;
    case (s)
      3'd0:    r = {16'd10, 16'd5, 16'd3, 16'd2};
      3'd1:    r = {16'd30, 16'd10, 16'd3, 16'd2};
      3'd2:    r = {16'd35, 16'd15, 16'd4, 16'd2};
      3'd3:    r = {16'd35, 16'd20, 16'd8, 16'd3};
      3'd4:    r = {16'd40, 16'd25, 16'd8, 16'd4};
      default: r = {16'd50, 16'd35, 16'd12, 16'd6};
    endcase
    return r;
  endfunction

  function automatic logic [LEVEL_W-1:0] grade_pm(input logic [PM_W-1:0] pm);
    logic [3:0][HOLD_W-1:0] row;
    logic [LEVEL_W-1:0]     lv;
    row = limit_row(sens_reg > SENS_MAX_ROW ? SENS_MAX_ROW : sens_reg);
    lv = '0;
    for (int k = 0; k < 4; k++) begin
      if (pm >= row[k]) lv++;
    end
    return lv;
  endfunction

  task automatic advance_indicator(input aqli_in_t w, output aqli_out_t r);
    logic [LEVEL_W-1:0] target;
    if (w.cmd == CMD_TICK) begin
      if (drop_armed && hold_left != 0) hold_left--;
    end else if (!w.freeze) begin
      target = grade_pm(w.pm_value);
      if (quick_drop_reg) hold_left = '0;
      if (target < shown) begin
        if (!drop_armed) begin
          drop_armed = 1'b1;
        end else if (hold_left == 0) begin
          shown--;
          hold_left = hold_reg;
        end
      end else begin
        drop_armed = 1'b0;
        hold_left = hold_reg;
        shown = target;
      end
    end
    r.level = shown;
    r.display_off = w.sleeping;
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!rx_calm && $urandom_range(0, 99) < 20) begin
      out_ready <= 1'b0;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (levels_due.size() == 0) begin
        flag_mismatch("result word with nothing pending, level", out_data.level, -1);
      end else begin
        due_word = levels_due.pop_front();
        if (out_data.level !== due_word.level) begin
          flag_mismatch("level", out_data.level, due_word.level);
        end
        if (out_data.display_off !== due_word.display_off) begin
          flag_mismatch("display_off", out_data.display_off, due_word.display_off);
        end
      end
    end
  end

  task automatic send_word(input aqli_in_t w, input bit typed, input aqli_out_t want);
    aqli_out_t r;
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    advance_indicator(w, r);
    levels_due.push_back(typed ? want : r);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (levels_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SENSITIVITY:       sens_reg = val[SENS_W-1:0];
      CFG_SLOW_DROP_DISABLE: quick_drop_reg = val[0];
      CFG_HOLD_SECONDS:      hold_reg = val[HOLD_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic int pick_gap();
    int r;
    if (tx_calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_with_gap(input aqli_in_t w, input bit typed, input aqli_out_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    send_word(w, typed, want);
  endtask

  function automatic plan_row_t word_row(input bit tick, input int pm, input bit frz,
                                         input bit slp, input bit typed = 1'b0,
                                         input int lvl = 0);
    plan_row_t p;
    p = '{default: '0};
    p.word.cmd = tick ? CMD_TICK : CMD_SAMPLE;
    p.word.pm_value = pm[PM_W-1:0];
    p.word.freeze = frz;
    p.word.sleeping = slp;
    p.typed = typed;
    p.want.level = lvl[LEVEL_W-1:0];
    p.want.display_off = slp;
    return p;
  endfunction

  function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx, input int val);
    plan_row_t p;
    p = '{default: '0};
    p.is_reg = 1'b1;
    p.idx = idx;
    p.val = val[CFG_DATA_W-1:0];
    return p;
  endfunction

  function automatic aqli_in_t random_word();
    aqli_in_t w;
    w.cmd = ($urandom_range(0, 99) < 40) ? CMD_TICK : CMD_SAMPLE;
    case ($urandom_range(0, 9))
      0:       w.pm_value = PM_W'($urandom);
      1:       w.pm_value = PM_W'($urandom_range(0, 255));
      default: w.pm_value = PM_W'($urandom_range(0, 60));
    endcase
    w.freeze = ($urandom_range(0, 9) == 0);
    w.sleeping = ($urandom_range(0, 3) == 0);
    return w;
  endfunction

  initial begin
    logic [SENS_W-1:0] s;
    logic              q;
    logic [HOLD_W-1:0] h;
    int                r;

    sens_reg = '0;
    quick_drop_reg = 1'b0;
    hold_reg = HOLD_SECONDS_RESET;
    shown = '0;
    drop_armed = 1'b0;
    hold_left = '0;

    plan.push_back(word_row(0, 0, 0, 0, 1, 0));
    plan.push_back(reg_row(CFG_HOLD_SECONDS, 2));
    plan.push_back(word_row(0, 65535, 0, 1, 1, 4));
    plan.push_back(word_row(0, 0, 1, 0, 1, 4));
    plan.push_back(word_row(1, 65535, 1, 1, 1, 4));
    plan.push_back(word_row(0, 1, 0, 0));
    plan.push_back(word_row(1, 0, 0, 0));
    plan.push_back(word_row(1, 0, 1, 0));
    plan.push_back(word_row(1, 0, 0, 1));
    plan.push_back(word_row(0, 1, 0, 0));
    plan.push_back(word_row(0, 4, 0, 0));
    plan.push_back(reg_row(CFG_SLOW_DROP_DISABLE, 1));
    plan.push_back(word_row(0, 1, 0, 0));
    plan.push_back(word_row(0, 1, 0, 1));
    plan.push_back(word_row(0, 1, 0, 0));
    plan.push_back(word_row(0, 2, 0, 0));
    plan.push_back(reg_row(CFG_SENSITIVITY, 7));
    plan.push_back(word_row(0, 5, 0, 0));
    plan.push_back(word_row(0, 50, 0, 0));
    plan.push_back(word_row(0, 49, 0, 0));
    plan.push_back(reg_row(CFG_SENSITIVITY, 3));
    plan.push_back(word_row(0, 65535, 0, 0, 1, 4));
    plan.push_back(reg_row(CFG_HOLD_SECONDS, 0));
    plan.push_back(reg_row(CFG_SLOW_DROP_DISABLE, 0));
    plan.push_back(word_row(0, 0, 0, 0));
    plan.push_back(word_row(0, 0, 0, 0));
    plan.push_back(word_row(0, 2, 0, 0));
    plan.push_back(word_row(0, 34, 0, 0));
    plan.push_back(word_row(0, 35, 0, 1));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        drain();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        send_with_gap(plan[i].word, plan[i].typed, plan[i].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin s = 3'd0; q = 1'b0; h = 16'd0; end
        1: begin s = 3'd7; q = 1'b1; h = 16'hFFFF; end
        2: begin s = 3'd6; q = 1'b0; h = 16'd1; end
        3: begin s = SENS_MAX_ROW; q = 1'b0; h = 16'hFFFF; end
        default: begin
          s = SENS_W'($urandom_range(0, 7));
          q = 1'($urandom_range(0, 1));
          r = $urandom_range(0, 7);
          if (r < 6) h = HOLD_W'($urandom_range(0, 4));
          else if (r == 6) h = HOLD_SECONDS_RESET;
          else h = HOLD_W'($urandom);
        end
      endcase
      tx_calm = (ph % 4 == 3) || (ph == 8);
      rx_calm = (ph % 4 == 1) || (ph == 8);
      drain();
      write_reg(CFG_SENSITIVITY, CFG_DATA_W'(s));
      write_reg(CFG_SLOW_DROP_DISABLE, CFG_DATA_W'(q));
      write_reg(CFG_HOLD_SECONDS, h);
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        send_with_gap(random_word(), 1'b0, '0);
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
